/* sv/sts_pkg.sv */
// Shared types and constants for the sorted table search counter.
// No dependencies; used by sts_engine and sorted_table_search_counter_core.
package sts_pkg;

    // Fixed field widths of the input and result words.
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 14;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 15;
    localparam int CNT_W   = 15;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_LINEAR = 2'd1,
        CMD_BINARY = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // One search result as handed from the engine to the output register.
    typedef struct packed {
        logic [CNT_W-1:0] comparisons;
        logic             found;
    } t_result;

endpackage

/* sv/sts_table.sv */
// Synchronous single-port-write, single-port-read table memory.
// One write and one registered read per cycle; no package dependencies.
module sts_table #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 32,
    parameter int AW    = 14
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port: the data follows the address in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/sts_engine.sv */
// Load and search sequencer: writes table entries and runs linear or binary
// searches against sts_table, one probe per cycle. Depends on sts_pkg.
module sts_engine #(
    parameter int TABLE_DEPTH = 16384,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 14,
    parameter int SW          = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Command word, valid when i_start is high.
    input  logic                      i_start,
    input  logic [sts_pkg::CMD_W-1:0] i_command,
    input  logic [sts_pkg::INDEX_W-1:0] i_index,
    input  logic [sts_pkg::DATA_W-1:0]  i_data,
    input  logic [sts_pkg::SIZE_W-1:0]  i_size,
    output logic                      o_busy,
    // Finished result.
    output logic                      o_res_valid,
    output sts_pkg::t_result          o_res,
    input  logic                      i_res_take,
    // Table memory port.
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [VALUE_WIDTH-1:0]    o_wr_data,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [VALUE_WIDTH-1:0]    i_rd_data
);

    localparam int LW = (SW > sts_pkg::SIZE_W) ? SW : sts_pkg::SIZE_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0]                r_lo, n_lo;
    logic [SW-1:0]                r_hi, n_hi;
    logic [SW-1:0]                r_mid, n_mid;
    logic [VALUE_WIDTH-1:0]       r_key, n_key;
    logic                         r_bin, n_bin;
    logic [sts_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_found, n_found;

    logic [VALUE_WIDTH+sts_pkg::DATA_W-1:0] w_ext;
    logic [VALUE_WIDTH-1:0] w_key;
    logic [SW-1:0]          w_hi0;
    logic [SW-1:0]          w_mid0;
    logic                   w_index_ok;
    logic                   w_eq;
    logic                   w_gt;
    logic [SW-1:0]          w_lo_step;
    logic [SW-1:0]          w_lo_nx;
    logic [SW-1:0]          w_hi_nx;
    logic [SW:0]            w_sum;
    logic [SW-1:0]          w_mid_nx;
    sts_pkg::t_cmd          w_cmd;

    // Order-preserving key: value at table width with its sign bit inverted.
    assign w_ext = {{VALUE_WIDTH{1'b0}}, i_data};
    assign w_key = w_ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    assign w_cmd = sts_pkg::t_cmd'(i_command);

    // Active size saturates to the table depth; loads beyond it are dropped.
    assign w_hi0      = (LW'(i_size) > LW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : SW'(i_size);
    assign w_mid0     = (w_hi0 - SW'(1)) >> 1;
    assign w_index_ok = LW'(i_index) < LW'(TABLE_DEPTH);

    // Probe outcome; linear mode never narrows from above.
    assign w_eq      = i_rd_data == r_key;
    assign w_gt      = i_rd_data > r_key;
    assign w_lo_step = r_mid + SW'(1);
    assign w_lo_nx   = (r_bin && w_gt) ? r_lo : w_lo_step;
    assign w_hi_nx   = (r_bin && w_gt) ? r_mid : r_hi;
    assign w_sum     = {1'b0, w_lo_nx} + {1'b0, w_hi_nx} - (SW+1)'(1);
    assign w_mid_nx  = r_bin ? w_sum[SW:1] : w_lo_nx;

    // Next-state logic. The range is kept half open as [lo, hi).
    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_key     = r_key;
        n_bin     = r_bin;
        n_count   = r_count;
        n_found   = r_found;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(i_index);
        o_wr_data = w_key;
        o_rd_en   = 1'b0;
        o_rd_addr = r_mid[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (w_cmd)
                        sts_pkg::CMD_LOAD: begin
                            o_wr_en = w_index_ok;
                        end
                        sts_pkg::CMD_LINEAR, sts_pkg::CMD_BINARY: begin
                            n_bin   = (w_cmd == sts_pkg::CMD_BINARY);
                            n_key   = w_key;
                            n_lo    = '0;
                            n_hi    = w_hi0;
                            n_mid   = (w_cmd == sts_pkg::CMD_BINARY) ? w_mid0 : '0;
                            n_count = '0;
                            n_found = 1'b0;
                            if (w_hi0 == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = n_mid[AW-1:0];
                                n_state   = ST_PROBE;
                            end
                        end
                        sts_pkg::CMD_NONE: begin
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                n_count = r_count + sts_pkg::CNT_W'(1);
                if (w_eq) begin
                    n_found = 1'b1;
                    n_state = ST_DONE;
                end else if (w_lo_nx >= w_hi_nx) begin
                    n_state = ST_DONE;
                end else begin
                    n_lo      = w_lo_nx;
                    n_hi      = w_hi_nx;
                    n_mid     = w_mid_nx;
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_mid_nx[AW-1:0];
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search payload.
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_bin   <= n_bin;
        r_count <= n_count;
        r_found <= n_found;
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_res_valid       = (r_state == ST_DONE);
    assign o_res.comparisons = r_count;
    assign o_res.found       = r_found;

endmodule

/* sv/sorted_table_search_counter_core.sv */
// Top level of the sorted table search counter: handshake, output register,
// and the sts_engine / sts_table pair. Depends on sts_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_stall   i_command, i_entry_index,
//                                                 i_data_value, i_active_size
//   output   out        o_out_valid / i_out_stall o_comparisons, o_found
//
// A load word is written to the table as it is accepted. A search word goes
// through an accept cycle, a probe state that reads one entry per cycle and a
// done state that hands the result to the output register; the probes are
// serial, set by the one read port of the table memory. Reset is synchronous
// and active low and clears control state only; table contents are undefined
// until loaded. The input is stalled while a search runs and until its result
// is handed to the output register; the result then waits there, so the next
// word is taken while the result is still pending.
module sorted_table_search_counter_core #(
    parameter int TABLE_DEPTH = 16384,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [sts_pkg::CMD_W-1:0]   i_command,
    input  logic [sts_pkg::INDEX_W-1:0] i_entry_index,
    input  logic signed [sts_pkg::DATA_W-1:0] i_data_value,
    input  logic [sts_pkg::SIZE_W-1:0]  i_active_size,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [sts_pkg::CNT_W-1:0]   o_comparisons,
    output logic                        o_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    logic                   w_accept;
    logic                   w_busy;
    logic                   w_res_valid;
    logic                   w_res_take;
    sts_pkg::t_result       w_res;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic [VALUE_WIDTH-1:0] w_rd_data;

    logic                   r_out_valid, n_out_valid;
    sts_pkg::t_result       r_out;

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    sts_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .SW          (SW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_command   (i_command),
        .i_index     (i_entry_index),
        .i_data      (i_data_value),
        .i_size      (i_active_size),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    sts_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // The output register takes a result when it is empty or being drained.
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_comparisons = r_out.comparisons;
    assign o_found       = r_out.found;

endmodule

/* verif/tb_sorted_table_search_counter_core.sv */
// Self-checking testbench for sorted_table_search_counter_core.
// Needs sts_pkg and the core RTL; keeps a shadow copy of the table and predicts
// the probe count and found flag of each search word that has no fixed expectation.
module tb_sorted_table_search_counter_core;

    localparam int CMD_W   = sts_pkg::CMD_W;
    localparam int INDEX_W = sts_pkg::INDEX_W;
    localparam int DATA_W  = sts_pkg::DATA_W;
    localparam int SIZE_W  = sts_pkg::SIZE_W;
    localparam int CNT_W   = sts_pkg::CNT_W;

    localparam int DEPTH = 16384;
    localparam int RANDOM_WORDS = 1100;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;

    // One row of the directed stimulus; want is used only when fixed is set.
    typedef struct packed {
        sts_pkg::t_cmd            cmd;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] value;
        logic [SIZE_W-1:0]        size;
        logic                     fixed;
        sts_pkg::t_result         want;
    } t_stim_row;

    localparam int N_DIRECTED = 25;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // Searches straight after reset with zero size touch no entry.
        '{sts_pkg::CMD_LINEAR, 14'd0,    32'sd0,         15'd0,     1'b1, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_BINARY, 14'd0,    32'sh1234_5678, 15'd0,     1'b1, '{15'd0, 1'b0}},
        // A small ascending table spanning both value extremes.
        '{sts_pkg::CMD_LOAD,   14'd0,    VMIN,           15'h7FFF,  1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'd1,    -32'sd5,        15'd0,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'd2,    32'sd0,         15'd0,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'd3,    32'sd7,         15'd0,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'd4,    VMAX,           15'd0,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'h3FFF, 32'sh5555_5555, 15'h7FFF,  1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LOAD,   14'd8191, 32'sd100,       15'd0,     1'b0, '{15'd0, 1'b0}},
        // The unused command is dropped without a result.
        '{sts_pkg::CMD_NONE,   14'h3FFF, 32'shFFFF_FFFF, 15'h7FFF,  1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    VMIN,           15'd5,     1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    VMAX,           15'd5,     1'b1, '{15'd5, 1'b1}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    32'sd1,         15'd5,     1'b1, '{15'd5, 1'b0}},
        '{sts_pkg::CMD_BINARY, 14'd0,    32'sd0,         15'd5,     1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_BINARY, 14'h2AAA, VMAX,           15'd5,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_BINARY, 14'd0,    VMIN,           15'd5,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_BINARY, 14'd0,    32'sd8,         15'd5,     1'b0, '{15'd0, 1'b0}},
        // Sizes beyond the table saturate; only entry 0 or the midpoint is read.
        '{sts_pkg::CMD_LINEAR, 14'd0,    VMIN,           15'h7FFF,  1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    VMIN,           15'd16384, 1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_BINARY, 14'd0,    32'sd100,       15'h7FFF,  1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_BINARY, 14'd0,    32'sd100,       15'd16384, 1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    -32'sd5,        15'd1,     1'b1, '{15'd1, 1'b0}},
        '{sts_pkg::CMD_BINARY, 14'd0,    VMIN,           15'd1,     1'b1, '{15'd1, 1'b1}},
        '{sts_pkg::CMD_NONE,   14'd0,    32'sd0,         15'd0,     1'b0, '{15'd0, 1'b0}},
        '{sts_pkg::CMD_LINEAR, 14'd0,    32'sd7,         15'd4,     1'b0, '{15'd0, 1'b0}}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = sts_pkg::CMD_NONE;
    logic [INDEX_W-1:0]       i_entry_index = '0;
    logic signed [DATA_W-1:0] i_data_value = '0;
    logic [SIZE_W-1:0]        i_active_size = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [CNT_W-1:0]         o_comparisons;
    logic                     o_found;

    // Shadow of the table contents and of which entries have been loaded.
    logic signed [DATA_W-1:0] entry_value [DEPTH];
    bit                       entry_loaded [DEPTH];

    sts_pkg::t_result search_results [$];
    sts_pkg::t_result oldest_result;
    int               fail_count = 0;
    int               word_count = 0;
    bit               quiet = 1'b0;

    sorted_table_search_counter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_data_value  (i_data_value),
        .i_active_size (i_active_size),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_comparisons (o_comparisons),
        .o_found       (o_found)
    );

    always #1 i_clk = ~i_clk;

    // Predict one search over the shadow table. gap returns the first entry the
    // search would read without it ever having been loaded, or -1.
    function automatic void predict_search(input sts_pkg::t_cmd cmd,
                                           input logic signed [DATA_W-1:0] target,
                                           input int size, output sts_pkg::t_result res,
                                           output int gap);
        int probes;
        bit hit;
        int span;
        int first;
        int last;
        int mid;
        probes = 0;
        hit = 1'b0;
        gap = -1;
        span = (size > DEPTH) ? DEPTH : size;
        if (cmd == sts_pkg::CMD_LINEAR) begin
            for (int i = 0; i < span && !hit; i++) begin
                if (!entry_loaded[i]) begin
                    gap = i;
                    break;
                end
                probes++;
                hit = (entry_value[i] == target);
            end
        end else begin
            first = 0;
            last = span - 1;
            while (first <= last && !hit && gap < 0) begin
                mid = (first + last) / 2;
                if (!entry_loaded[mid]) begin
                    gap = mid;
                end else begin
                    probes++;
                    if (entry_value[mid] == target)
                        hit = 1'b1;
                    else if (entry_value[mid] > target)
                        last = mid - 1;
                    else
                        first = mid + 1;
                end
            end
        end
        res.comparisons = (probes > 32767) ? 15'h7FFF : CNT_W'(probes);
        res.found = hit;
    endfunction

    // Present one word, wait until it is taken, and queue the expected result of a search.
    task automatic send_word(input sts_pkg::t_cmd cmd, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] value,
                             input logic [SIZE_W-1:0] size, input bit fixed,
                             input sts_pkg::t_result fixed_res);
        sts_pkg::t_result res;
        int               gap;
        res = fixed_res;
        if ((cmd == sts_pkg::CMD_LINEAR || cmd == sts_pkg::CMD_BINARY) && !fixed)
            predict_search(cmd, value, int'(size), res, gap);
        if (cmd == sts_pkg::CMD_LOAD) begin
            entry_value[idx] = value;
            entry_loaded[idx] = 1'b1;
            word_count++;
        end
        while (!quiet && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_entry_index <= idx;
        i_data_value <= value;
        i_active_size <= size;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == sts_pkg::CMD_LINEAR || cmd == sts_pkg::CMD_BINARY) begin
            search_results.push_back(res);
            word_count++;
        end
    endtask

    // A random search over a table whose first table_size entries are loaded.
    // Oversized binary searches get their probe path loaded first; an oversized
    // linear miss falls back to a size inside the loaded table.
    task automatic random_search(input int table_size);
        sts_pkg::t_cmd            cmd;
        logic signed [DATA_W-1:0] target;
        int                       size;
        int                       k;
        int                       gap;
        sts_pkg::t_result         res;
        cmd = $urandom_range(1) ? sts_pkg::CMD_BINARY : sts_pkg::CMD_LINEAR;
        k = $urandom_range(table_size - 1);
        case ($urandom_range(3))
            0, 1: target = entry_value[k];
            2: target = $urandom;
            default: target = entry_value[k] + ($urandom_range(1) ? 1 : -1);
        endcase
        case ($urandom_range(9))
            0: size = $urandom_range(32767);
            1: size = $urandom_range(table_size);
            default: size = table_size;
        endcase
        predict_search(cmd, target, size, res, gap);
        if (cmd == sts_pkg::CMD_LINEAR) begin
            if (gap >= 0)
                size = $urandom_range(table_size);
        end else begin
            while (gap >= 0) begin
                send_word(sts_pkg::CMD_LOAD, INDEX_W'(gap), $urandom, '0, 1'b0, '0);
                predict_search(cmd, target, size, res, gap);
            end
        end
        send_word(cmd, INDEX_W'($urandom_range(DEPTH - 1)), target, SIZE_W'(size),
                  1'b0, '0);
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (search_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual comparisons %0d found %0b",
                         $time, o_comparisons, o_found);
                fail_count++;
            end else begin
                oldest_result = search_results.pop_front();
                if (o_comparisons !== oldest_result.comparisons) begin
                    $display("%0t: comparisons mismatch: expected %0d actual %0d",
                             $time, oldest_result.comparisons, o_comparisons);
                    fail_count++;
                end
                if (o_found !== oldest_result.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, oldest_result.found, o_found);
                    fail_count++;
                end
            end
        end
    end

    // The receiver stalls at random, except in the quiet stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 13);
    end

    // Directed rows, then random tables followed by searches over them.
    initial begin
        int     table_size;
        int     random_base;
        longint span;
        longint v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++)
            send_word(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].value,
                      DIRECTED[r].size, DIRECTED[r].fixed, DIRECTED[r].want);

        table_size = 5;
        random_base = word_count;
        while (word_count - random_base < RANDOM_WORDS) begin
            quiet = (word_count - random_base >= 450) && (word_count - random_base < 700);
            if ($urandom_range(9) < 7) begin
                // Load a fresh ascending table, then search it several times.
                table_size = ($urandom_range(9) == 0) ? $urandom_range(41, 256)
                                                      : $urandom_range(1, 40);
                if ($urandom_range(1)) begin
                    // Wide spread: one value per slice of the full signed range.
                    span = 64'sd4294967296 / table_size;
                    for (int i = 0; i < table_size; i++) begin
                        v = -64'sd2147483648 + i * span + longint'($urandom) % span;
                        send_word(sts_pkg::CMD_LOAD, INDEX_W'(i), v[DATA_W-1:0],
                                  SIZE_W'($urandom_range(32767)), 1'b0, '0);
                    end
                end else begin
                    // Tight run with repeated values.
                    v = longint'($signed($urandom));
                    if (v > 64'sd2147483647 - 4 * table_size)
                        v = v - 4 * table_size;
                    for (int i = 0; i < table_size; i++) begin
                        send_word(sts_pkg::CMD_LOAD, INDEX_W'(i), v[DATA_W-1:0],
                                  SIZE_W'($urandom_range(32767)), 1'b0, '0);
                        v = v + $urandom_range(3);
                    end
                end
                repeat ($urandom_range(2, 8)) random_search(table_size);
            end else begin
                // Noise: unused commands, far loads and stray searches.
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(2))
                        0: send_word(sts_pkg::CMD_NONE, INDEX_W'($urandom), $urandom,
                                     SIZE_W'($urandom), 1'b0, '0);
                        1: send_word(sts_pkg::CMD_LOAD,
                                     INDEX_W'($urandom_range(table_size, DEPTH - 1)),
                                     $urandom, SIZE_W'($urandom), 1'b0, '0);
                        default: random_search(table_size);
                    endcase
                end
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (search_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
